/* src/bcc_pkg.sv */
// ----------------------------------------------------------------------------
// bcc_pkg: shared types and constants of the box collision and crush check
// Beat layouts, player state, hitbox registers, operation and side codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcc_pkg;

    // Width of the pixel arithmetic in the box test (covers all sums).
    localparam int C_PIX_W = 20;

    // Operation codes of an input beat.
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_BOX    = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HITBOX_LEFT   = 2'd0;
    localparam logic [1:0] CFG_HITBOX_TOP    = 2'd1;
    localparam logic [1:0] CFG_HITBOX_RIGHT  = 2'd2;
    localparam logic [1:0] CFG_HITBOX_BOTTOM = 2'd3;

    // Hitbox offsets after reset.
    localparam logic signed [7:0] C_RST_LEFT   = -8'sd10;
    localparam logic signed [7:0] C_RST_TOP    = -8'sd20;
    localparam logic signed [7:0] C_RST_RIGHT  = 8'sd10;
    localparam logic signed [7:0] C_RST_BOTTOM = 8'sd20;

    // Sticky flag bit positions.
    localparam int C_STICKY_GSPEED = 0;
    localparam int C_STICKY_UNLOCK = 1;
    localparam int C_STICKY_FLOOR  = 2;

    // Hit accumulator bit positions.
    localparam int C_HIT_LO = 0;   // left or top
    localparam int C_HIT_HI = 1;   // right or bottom

    typedef enum logic [2:0] {
        SIDE_NONE   = 3'd0,
        SIDE_TOP    = 3'd1,
        SIDE_LEFT   = 3'd2,
        SIDE_RIGHT  = 3'd3,
        SIDE_BOTTOM = 3'd4
    } t_side;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] player_pos_x;
        logic signed [31:0] player_pos_y;
        logic signed [31:0] player_speed_x;
        logic signed [31:0] player_speed_y;
        logic               player_grounded;
        logic signed [15:0] box_center_x;
        logic signed [15:0] box_center_y;
        logic [7:0]         box_width;
        logic [7:0]         box_height;
        logic               box_no_crush;
        logic               box_skipped;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]         contact_side;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_speed_y;
        logic               out_grounded;
        logic signed [31:0] out_ground_speed;
        logic               ground_speed_set;
        logic               control_unlocked;
        logic               floor_mode_set;
        logic               crushed;
    } t_out_beat;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] top;
        logic signed [7:0] right;
        logic signed [7:0] bottom;
    } t_hitbox;

    typedef struct packed {
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] speed_x;
        logic [31:0] speed_y;
        logic        grounded;
        logic [31:0] ground_speed;
        logic [2:0]  sticky;
        logic [1:0]  h_hits;
        logic [1:0]  v_hits;
    } t_state;

endpackage

/* src/bcc_step.sv */
// ----------------------------------------------------------------------------
// bcc_step: one beat of the player state update
// Box overlap tests, side choice, pushout, speed and flag update, crush verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcc_step
    import bcc_pkg::*;
(
    input  t_in_beat i_beat,
    input  t_hitbox  i_hitbox,
    input  t_state   i_state,
    output t_state   o_state,
    output t_side    o_side,
    output logic     o_crushed
);

    logic signed [C_PIX_W-1:0] px, py, bx, by, hw, hh;
    logic signed [C_PIX_W-1:0] off_l, off_t, off_r, off_b;
    logic signed [C_PIX_W-1:0] nx_pix, ny_pix;
    logic                      y_span, x_span_t, x_span_b;
    logic                      h_hit, v_hit, pick_v;
    t_side                     side_h, side_v, side;
    logic [31:0]               nx, ny, dx, dy;
    logic signed [16:0]        cx, cy;
    logic [16:0]               abs_cx, abs_cy;
    logic                      land;

    // Extend positions, box geometry and offsets to the pixel width.
    assign px    = {{(C_PIX_W-16){i_state.pos_x[31]}}, i_state.pos_x[31:16]};
    assign py    = {{(C_PIX_W-16){i_state.pos_y[31]}}, i_state.pos_y[31:16]};
    assign bx    = {{(C_PIX_W-16){i_beat.box_center_x[15]}}, i_beat.box_center_x};
    assign by    = {{(C_PIX_W-16){i_beat.box_center_y[15]}}, i_beat.box_center_y};
    assign hw    = C_PIX_W'({i_beat.box_width, 3'b000}) + C_PIX_W'(8);
    assign hh    = C_PIX_W'({i_beat.box_height, 3'b000}) + C_PIX_W'(8);
    assign off_l = {{(C_PIX_W-8){i_hitbox.left[7]}}, i_hitbox.left};
    assign off_t = {{(C_PIX_W-8){i_hitbox.top[7]}}, i_hitbox.top};
    assign off_r = {{(C_PIX_W-8){i_hitbox.right[7]}}, i_hitbox.right};
    assign off_b = {{(C_PIX_W-8){i_hitbox.bottom[7]}}, i_hitbox.bottom};

    // Overlap of the spans across each axis.
    assign y_span   = (by - hh < py + off_b - 1) && (by + hh > py + off_t + 1);
    assign x_span_t = (bx - hw < px + off_r - 1) && (bx + hw > px + off_l + 1);
    assign x_span_b = (bx - hw < px + off_r - 1) && (px + off_l + 1 < bx + hw);

    // Horizontal test: left half pushes left, right half pushes right.
    always_comb begin
        side_h = SIDE_NONE;
        nx_pix = bx - hw - off_r;
        if (px <= bx) begin
            if ((px + off_r >= bx - hw) && y_span) begin
                side_h = SIDE_LEFT;
            end
        end else begin
            nx_pix = bx + hw - off_l;
            if ((px + off_l < bx + hw) && y_span) begin
                side_h = SIDE_RIGHT;
            end
        end
    end

    // Vertical test: upper half lands on top, lower half bumps the bottom.
    always_comb begin
        side_v = SIDE_NONE;
        ny_pix = by - hh - off_b;
        if (py < by) begin
            if ((py + off_b >= by - hh) && x_span_t) begin
                side_v = SIDE_TOP;
            end
        end else begin
            ny_pix = by + hh - off_t;
            if ((py + off_t < by + hh) && x_span_b) begin
                side_v = SIDE_BOTTOM;
            end
        end
    end

    assign h_hit = (side_h != SIDE_NONE);
    assign v_hit = (side_v != SIDE_NONE);
    assign nx    = h_hit ? {nx_pix[15:0], 16'h0000} : i_state.pos_x;
    assign ny    = v_hit ? {ny_pix[15:0], 16'h0000} : i_state.pos_y;

    // Penetration depths in whole pixels; compare magnitudes.
    assign dx     = nx - i_state.pos_x;
    assign dy     = ny - i_state.pos_y;
    assign cx     = {dx[31], dx[31:16]};
    assign cy     = {dy[31], dy[31:16]};
    assign abs_cx = cx[16] ? 17'(-cx) : 17'(cx);
    assign abs_cy = cy[16] ? 17'(-cy) : 17'(cy);

    // Pick the side: smaller penetration wins, ties and lone vertical go vertical.
    assign pick_v = ((abs_cx >= abs_cy) && (v_hit || !h_hit)) || (!h_hit && v_hit);
    assign side   = pick_v ? side_v : side_h;
    assign land   = !i_state.grounded && !i_state.speed_y[31];

    // Apply the operation to the state.
    always_comb begin
        o_state   = i_state;
        o_side    = SIDE_NONE;
        o_crushed = 1'b0;
        unique case (i_beat.operation)
            OP_LOAD: begin
                o_state.pos_x        = i_beat.player_pos_x;
                o_state.pos_y        = i_beat.player_pos_y;
                o_state.speed_x      = i_beat.player_speed_x;
                o_state.speed_y      = i_beat.player_speed_y;
                o_state.grounded     = i_beat.player_grounded;
                o_state.ground_speed = '0;
                o_state.sticky       = '0;
                o_state.h_hits       = '0;
                o_state.v_hits       = '0;
            end
            OP_BOX: begin
                if (!i_beat.box_skipped) begin
                    o_side = side;
                    case (side)
                        SIDE_TOP: begin
                            o_state.pos_y = ny;
                            if (!i_state.speed_y[31]) begin
                                o_state.speed_y = '0;
                            end
                            if (land) begin
                                o_state.ground_speed            = i_state.speed_x;
                                o_state.grounded                = 1'b1;
                                o_state.sticky[C_STICKY_GSPEED] = 1'b1;
                            end
                            o_state.sticky[C_STICKY_UNLOCK] = 1'b1;
                            o_state.sticky[C_STICKY_FLOOR]  = 1'b1;
                            if (!i_beat.box_no_crush) begin
                                o_state.v_hits[C_HIT_LO] = 1'b1;
                            end
                        end
                        SIDE_LEFT, SIDE_RIGHT: begin
                            o_state.pos_x                   = nx;
                            o_state.sticky[C_STICKY_UNLOCK] = 1'b1;
                            if (!i_beat.box_no_crush) begin
                                if (side == SIDE_LEFT) begin
                                    o_state.h_hits[C_HIT_LO] = 1'b1;
                                end else begin
                                    o_state.h_hits[C_HIT_HI] = 1'b1;
                                end
                            end
                        end
                        SIDE_BOTTOM: begin
                            o_state.pos_y = ny;
                            if (i_state.speed_y[31]) begin
                                o_state.speed_y = '0;
                            end
                            if (!i_beat.box_no_crush) begin
                                o_state.v_hits[C_HIT_HI] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            OP_FINISH: begin
                o_crushed = (&i_state.h_hits) || (&i_state.v_hits);
            end
            default: begin
            end
        endcase
    end

endmodule

/* src/box_collision_crush_check_top.sv */
// ----------------------------------------------------------------------------
// box_collision_crush_check_top: player against solid box collision
// Pushes a loaded player out of boxes and reports crushes per frame.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (i_in_valid / o_in_stall / i_in_beat) carries one beat
//   per operation: load player, test one box, or finish the frame. Every
//   input beat yields exactly one result beat on the output channel
//   (o_out_valid / i_out_stall / o_out_beat) with the player state after it.
//   The beat sits in the input register, and the box test runs between that
//   register and the result register, which loads when it is free.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   state update (player position, speeds, flags) is a loop from the state
//   register back to itself, which allows this rate.
//   Hitbox offsets are written through i_cfg_wr_en / i_cfg_index / i_cfg_data
//   by the user only while no beat is in flight; the block does not enforce it.
//   Reset loads the default hitbox, clears the player state and empties
//   both registers. When the receiver stalls, the result register holds,
//   the input register still fills, and o_in_stall rises once both are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module box_collision_crush_check_top
    import bcc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_wr_en,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_beat,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_beat
);

    t_hitbox   r_hitbox;
    t_state    r_state;
    t_state    n_state;
    t_in_beat  r_in_beat;
    logic      r_in_valid;
    t_out_beat r_out_beat;
    t_out_beat n_out_beat;
    logic      r_out_valid;
    t_side     step_side;
    logic      step_crushed;
    logic      out_free;
    logic      advance;

    // Handshake: the result register frees up when empty or taken.
    assign out_free    = !r_out_valid || !i_out_stall;
    assign advance     = r_in_valid && out_free;
    assign o_in_stall  = r_in_valid && !out_free;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

    bcc_step u_step (
        .i_beat    (r_in_beat),
        .i_hitbox  (r_hitbox),
        .i_state   (r_state),
        .o_state   (n_state),
        .o_side    (step_side),
        .o_crushed (step_crushed)
    );

    // Build the result beat from the updated state.
    always_comb begin
        n_out_beat.contact_side     = step_side;
        n_out_beat.out_pos_x        = n_state.pos_x;
        n_out_beat.out_pos_y        = n_state.pos_y;
        n_out_beat.out_speed_y      = n_state.speed_y;
        n_out_beat.out_grounded     = n_state.grounded;
        n_out_beat.out_ground_speed = n_state.ground_speed;
        n_out_beat.ground_speed_set = n_state.sticky[C_STICKY_GSPEED];
        n_out_beat.control_unlocked = n_state.sticky[C_STICKY_UNLOCK];
        n_out_beat.floor_mode_set   = n_state.sticky[C_STICKY_FLOOR];
        n_out_beat.crushed          = step_crushed;
    end

    // Write hitbox registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hitbox.left   <= C_RST_LEFT;
            r_hitbox.top    <= C_RST_TOP;
            r_hitbox.right  <= C_RST_RIGHT;
            r_hitbox.bottom <= C_RST_BOTTOM;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_HITBOX_LEFT:   r_hitbox.left   <= i_cfg_data;
                CFG_HITBOX_TOP:    r_hitbox.top    <= i_cfg_data;
                CFG_HITBOX_RIGHT:  r_hitbox.right  <= i_cfg_data;
                CFG_HITBOX_BOTTOM: r_hitbox.bottom <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Advance the input register, the player state and the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (!r_in_valid || advance) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold payloads; no reset needed.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_beat <= i_in_beat;
        end
        if (advance) begin
            r_out_beat <= n_out_beat;
        end
    end

endmodule
